// ===== design/mld_pkg.sv =====
// Package for the magic/length deframer: word types, region and status codes,
// frame layout constants. No dependencies.
package mld_pkg;

   localparam logic [15:0] HEAD_MAGIC_RESET = 16'h4567;
   localparam logic [15:0] TAIL_MAGIC_RESET = 16'h89AB;

   // byte offsets of the fixed header fields
   localparam logic [31:0] POS_CMD       = 32'd2;
   localparam logic [31:0] POS_HLEN      = 32'd4;
   localparam logic [31:0] POS_BLEN      = 32'd6;
   localparam logic [31:0] HEADER_LEN    = 32'd10;
   localparam logic [31:0] POS_CMD_DONE  = 32'd3;
   localparam logic [31:0] POS_HLEN_DONE = 32'd5;
   localparam logic [31:0] POS_BLEN_DONE = 32'd9;
   // last byte index below this means buffer shorter than the minimum frame
   localparam logic [31:0] MIN_LAST_POS  = 32'd11;

   typedef enum logic [1:0] {
      REGION_FIXED  = 2'd0,
      REGION_HEAD   = 2'd1,
      REGION_BODY   = 2'd2,
      REGION_BEYOND = 2'd3
   } region_type;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_UNDER_MIN  = 3'd1,
      STATUS_HEAD_MAGIC = 3'd2,
      STATUS_SHORT      = 3'd3,
      STATUS_TAIL_MAGIC = 3'd4
   } status_type;

   typedef enum logic {
      CSR_HEAD_MAGIC = 1'b0,
      CSR_TAIL_MAGIC = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } in_word_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      region_type  region;
      logic [15:0] command_id;
      logic [15:0] head_length;
      logic [31:0] body_length;
      logic        done_res;
      status_type  status;
   } rsp_word_type;

endpackage

// ===== design/mld_in_reg.sv =====
// Input register stage of the deframer: holds one accepted word.
// Depends on mld_pkg.
module mld_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  mld_pkg::in_word_type in_word,
   output logic                in_ready,
   input  logic                take,
   output logic                out_valid,
   output mld_pkg::in_word_type out_word
);

   logic                 valid_ff, valid_in;
   mld_pkg::in_word_type word_ff;

   assign in_ready  = !valid_ff || take;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= in_word;
      end
   end

endmodule

// ===== design/mld_parser.sv =====
// Frame tracker: position counter, captured header/tail words, region and
// verdict logic, magic registers. Depends on mld_pkg.
module mld_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  mld_pkg::csr_index_type csr_index,
   input  logic [15:0]           csr_wdata,
   input  logic                  step,
   input  mld_pkg::in_word_type  in_word,
   output mld_pkg::rsp_word_type rsp_word
);

   logic [15:0] head_magic_ff, tail_magic_ff;
   logic [31:0] pos_ff, pos_in;
   logic [15:0] head_ff, head_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [15:0] hsize_ff, hsize_in;
   logic [31:0] bsize_ff, bsize_in;
   logic [15:0] tail_ff, tail_in;
   logic        seen_ff, seen_in;

   logic [33:0] pos_w, head_end, tail_at;
   logic [7:0]  b;
   mld_pkg::region_type region;
   mld_pkg::status_type status;

   assign b        = in_word.data_byte;
   assign pos_w    = {2'b00, pos_ff};
   // sizes are final once past the fixed header, which is where these matter
   assign head_end = {2'b00, mld_pkg::HEADER_LEN} + {18'd0, hsize_ff};
   assign tail_at  = head_end + {2'b00, bsize_ff};

   always_comb begin
      head_in  = head_ff;
      cmd_in   = cmd_ff;
      hsize_in = hsize_ff;
      bsize_in = bsize_ff;
      tail_in  = tail_ff;
      seen_in  = seen_ff;
      if (pos_ff < mld_pkg::POS_CMD) begin
         head_in = {head_ff[7:0], b};
      end else if (pos_ff < mld_pkg::POS_HLEN) begin
         cmd_in = {cmd_ff[7:0], b};
      end else if (pos_ff < mld_pkg::POS_BLEN) begin
         hsize_in = {hsize_ff[7:0], b};
      end else if (pos_ff < mld_pkg::HEADER_LEN) begin
         bsize_in = {bsize_ff[23:0], b};
      end

      if (pos_ff < mld_pkg::HEADER_LEN) begin
         region = mld_pkg::REGION_FIXED;
      end else if (pos_w < head_end) begin
         region = mld_pkg::REGION_HEAD;
      end else if (pos_w < tail_at) begin
         region = mld_pkg::REGION_BODY;
      end else if (pos_w == tail_at) begin
         region  = mld_pkg::REGION_FIXED;
         tail_in = {8'h00, b};
         seen_in = 1'b0;
      end else if (pos_w == tail_at + 34'd1) begin
         region  = mld_pkg::REGION_FIXED;
         tail_in = {tail_ff[7:0], b};
         seen_in = 1'b1;
      end else begin
         region = mld_pkg::REGION_BEYOND;
      end
   end

   // verdict, first failing check wins
   always_comb begin
      status = mld_pkg::STATUS_OK;
      if (in_word.last_byte) begin
         if (pos_ff < mld_pkg::MIN_LAST_POS) begin
            status = mld_pkg::STATUS_UNDER_MIN;
         end else if (head_ff != head_magic_ff) begin
            status = mld_pkg::STATUS_HEAD_MAGIC;
         end else if (pos_w <= tail_at) begin
            status = mld_pkg::STATUS_SHORT;
         end else if (!seen_in || tail_in != tail_magic_ff) begin
            status = mld_pkg::STATUS_TAIL_MAGIC;
         end
      end
   end

   always_comb begin
      rsp_word.out_byte    = b;
      rsp_word.region      = region;
      rsp_word.command_id  = (pos_ff >= mld_pkg::POS_CMD_DONE)  ? cmd_in   : 16'd0;
      rsp_word.head_length = (pos_ff >= mld_pkg::POS_HLEN_DONE) ? hsize_in : 16'd0;
      rsp_word.body_length = (pos_ff >= mld_pkg::POS_BLEN_DONE) ? bsize_in : 32'd0;
      rsp_word.done_res    = in_word.last_byte;
      rsp_word.status      = status;
   end

   // position saturates at all ones
   assign pos_in = (&pos_ff) ? pos_ff : pos_ff + 32'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_magic_ff <= mld_pkg::HEAD_MAGIC_RESET;
         tail_magic_ff <= mld_pkg::TAIL_MAGIC_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mld_pkg::CSR_HEAD_MAGIC: head_magic_ff <= csr_wdata;
            mld_pkg::CSR_TAIL_MAGIC: tail_magic_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && in_word.last_byte)) begin
         pos_ff   <= '0;
         head_ff  <= '0;
         cmd_ff   <= '0;
         hsize_ff <= '0;
         bsize_ff <= '0;
         tail_ff  <= '0;
         seen_ff  <= 1'b0;
      end else if (step) begin
         pos_ff   <= pos_in;
         head_ff  <= head_in;
         cmd_ff   <= cmd_in;
         hsize_ff <= hsize_in;
         bsize_ff <= bsize_in;
         tail_ff  <= tail_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

// ===== design/mld_out_reg.sv =====
// Result register of the deframer: holds one finished word until taken.
// Depends on mld_pkg.
module mld_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  mld_pkg::rsp_word_type in_word,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mld_pkg::rsp_word_type out_word
);

   logic                  valid_ff, valid_in;
   mld_pkg::rsp_word_type word_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= in_word;
      end
   end

endmodule

// ===== design/magic_length_deframer_core.sv =====
// Top level of the magic/length deframer: input register, frame tracker and
// result register. Depends on mld_pkg, mld_in_reg, mld_parser, mld_out_reg.
//
//  channel | direction | handshake            | contents
//  --------+-----------+----------------------+------------------------------------
//  req_    | in        | tvalid/tready        | tdata byte, tlast end of buffer
//  rsp_    | out       | tvalid/tready        | tdata echo+fields+status, tuser
//          |           |                      | region, tlast verdict valid
//  csr_    | in        | wr_en, no wait       | index 0 head magic, 1 tail magic
//
// One word per cycle sustained while rsp_tready stays high; each word passes through the
// input register, then the result register, with the parse logic between.
// Reset is synchronous, active high; it clears both stages, the position counter
// and the captured header, and loads the default magics.
// A stall on rsp_ fills the result register, then the input register; req_tready
// drops only when both hold a word and rsp_tready is low.
// The tracker state returns to its reset value after every word marked tlast.
module magic_length_deframer_core (
   input  logic        clock,
   input  logic        reset,
   // slave side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // master side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [7:0] out_byte, [23:8] command_id,
                                    // [39:24] head_length, [71:40] body_length,
                                    // [74:72] status, [79:75] zero
   output logic [1:0]  rsp_tuser,   // [1:0] region
   output logic        rsp_tlast,   // done_res
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   mld_pkg::in_word_type  req_word, stage_word;
   mld_pkg::rsp_word_type calc_word, rsp_word;
   logic                  stage_valid;
   logic                  out_ready;
   logic                  advance;

   assign req_word.data_byte = req_tdata;
   assign req_word.last_byte = req_tlast;

   // a word leaves the input register when the result register can take it
   assign advance = stage_valid && out_ready;

   mld_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_word   (req_word),
      .in_ready  (req_tready),
      .take      (out_ready),
      .out_valid (stage_valid),
      .out_word  (stage_word)
   );

   // tracker state moves only on the cycle the word is handed on
   mld_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (mld_pkg::csr_index_type'(csr_index)),
      .csr_wdata (csr_wdata),
      .step      (advance),
      .in_word   (stage_word),
      .rsp_word  (calc_word)
   );

   mld_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid),
      .in_word   (calc_word),
      .in_ready  (out_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_word)
   );

   assign rsp_tdata = {5'd0, rsp_word.status, rsp_word.body_length,
                       rsp_word.head_length, rsp_word.command_id, rsp_word.out_byte};
   assign rsp_tuser = rsp_word.region;
   assign rsp_tlast = rsp_word.done_res;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for magic_length_deframer_core: byte stream in, echoed words out.
// Holds its own model of the frame tracker; depends on mld_pkg and the core RTL.
module testbench;

   localparam int          WATCHDOG_LIMIT = 2000;  // idle cycles before giving up
   localparam int          HOLD_CYCLES    = 120;   // long back-pressure stretch on rsp_
   localparam int          SETTLE_CYCLES  = 4;     // two pipeline stages plus margin
   localparam logic [63:0] MIN_FRAME      = 64'd12;

   // one row of the directed part; status is only used where typed is set
   typedef struct packed {
      logic [7:0]          data;
      logic                last;
      logic                typed;
      mld_pkg::status_type status;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = 16'h0000;

   magic_length_deframer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Frame tracker model: magics, byte position and the captured header words
   // ---------------------------------------------------------------------------
   logic [15:0] cfg_head_magic;
   logic [15:0] cfg_tail_magic;
   logic [31:0] byte_pos;
   logic [15:0] cap_magic;
   logic [15:0] cap_cmd;
   logic [15:0] cap_hlen;
   logic [31:0] cap_blen;
   logic [15:0] cap_tail;
   logic        tail_complete;

   mld_pkg::rsp_word_type deframed_q[$];   // expected words, oldest first
   logic [7:0]   frame_q[$];      // buffer being built for the sender
   int           error_count = 0;
   int           words_checked = 0;
   int           sent_count = 0;
   int           idle_count = 0;
   bit           idling_on = 1'b0;
   bit           hold_pending = 1'b0;
   int           hold_left = 0;
   int           stall_left = 0;

   function automatic void clear_capture();
      byte_pos      = '0;
      cap_magic     = '0;
      cap_cmd       = '0;
      cap_hlen      = '0;
      cap_blen      = '0;
      cap_tail      = '0;
      tail_complete = 1'b0;
   endfunction

   // Word the core should emit for one accepted byte; advances the tracker.
   function automatic mld_pkg::rsp_word_type deframe_byte(input logic [7:0] b,
                                                          input logic last);
      mld_pkg::rsp_word_type w;
      logic [63:0]  p;
      logic [63:0]  tail_at;
      p = {32'd0, byte_pos};

      if (p < mld_pkg::POS_CMD)
         cap_magic = {cap_magic[7:0], b};
      else if (p < mld_pkg::POS_HLEN)
         cap_cmd = {cap_cmd[7:0], b};
      else if (p < mld_pkg::POS_BLEN)
         cap_hlen = {cap_hlen[7:0], b};
      else if (p < mld_pkg::HEADER_LEN)
         cap_blen = {cap_blen[23:0], b};

      // 64-bit sums: declared lengths must not wrap
      tail_at = mld_pkg::HEADER_LEN + cap_hlen + cap_blen;

      if (p < mld_pkg::HEADER_LEN) begin
         w.region = mld_pkg::REGION_FIXED;
      end else if (p < mld_pkg::HEADER_LEN + cap_hlen) begin
         w.region = mld_pkg::REGION_HEAD;
      end else if (p < tail_at) begin
         w.region = mld_pkg::REGION_BODY;
      end else if (p < tail_at + 2) begin
         w.region = mld_pkg::REGION_FIXED;
         if (p == tail_at) begin
            cap_tail      = {8'd0, b};
            tail_complete = 1'b0;
         end else begin
            cap_tail      = {cap_tail[7:0], b};
            tail_complete = 1'b1;
         end
      end else begin
         w.region = mld_pkg::REGION_BEYOND;
      end

      w.out_byte    = b;
      w.command_id  = (p >= mld_pkg::POS_CMD_DONE)  ? cap_cmd  : 16'd0;
      w.head_length = (p >= mld_pkg::POS_HLEN_DONE) ? cap_hlen : 16'd0;
      w.body_length = (p >= mld_pkg::POS_BLEN_DONE) ? cap_blen : 32'd0;
      w.done_res    = last;
      w.status      = mld_pkg::STATUS_OK;

      if (last) begin
         if (p + 1 < MIN_FRAME)
            w.status = mld_pkg::STATUS_UNDER_MIN;
         else if (cap_magic != cfg_head_magic)
            w.status = mld_pkg::STATUS_HEAD_MAGIC;
         else if (MIN_FRAME + cap_hlen + cap_blen > p + 1)
            w.status = mld_pkg::STATUS_SHORT;
         else if (!tail_complete || cap_tail != cfg_tail_magic)
            w.status = mld_pkg::STATUS_TAIL_MAGIC;
         clear_capture();
      end else if (byte_pos != 32'hFFFF_FFFF) begin
         byte_pos = byte_pos + 1;   // saturates on an endless buffer
      end
      return w;
   endfunction

   // ---------------------------------------------------------------------------
   // Sender side: one byte per call, entered and left at a falling edge
   // ---------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                            input mld_pkg::status_type st);
      mld_pkg::rsp_word_type w;
      int           gap;
      if (idling_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 18);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      w = deframe_byte(b, last);
      if (typed)
         w.status = st;   // verdict typed into the directed table
      deframed_q.push_back(w);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic put16(input logic [15:0] v);
      frame_q.push_back(v[15:8]);
      frame_q.push_back(v[7:0]);
   endtask

   task automatic put32(input logic [31:0] v);
      put16(v[31:16]);
      put16(v[15:0]);
   endtask

   task automatic put_random(input int n);
      repeat (n) frame_q.push_back(8'($urandom));
   endtask

   task automatic send_frame();
      int n;
      n = frame_q.size();
      for (int i = 0; i < n; i++)
         send_byte(frame_q[i], i == n - 1, 1'b0, mld_pkg::STATUS_OK);
      frame_q.delete();
   endtask

   // Mostly well-formed frames with random content, some broken, some noise.
   task automatic random_traffic(input int n_bytes);
      int          stop_at;
      int          kind;
      int          hlen;
      int          blen;
      int          cut;
      int          at;
      stop_at = sent_count + n_bytes;
      while (sent_count < stop_at) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            hlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4);
            blen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
            put16(cfg_head_magic);
            put16(16'($urandom));
            put16(16'(hlen));
            put32(32'(blen));
            put_random(hlen + blen);
            put16(cfg_tail_magic);
            if ($urandom_range(0, 3) == 0)
               put_random($urandom_range(1, 3));   // trailing bytes past the frame
            case ($urandom_range(0, 9))
               0: begin   // corrupt head magic
                  at = $urandom_range(0, 1);
                  frame_q[at] = frame_q[at] ^ (8'h01 << $urandom_range(0, 7));
               end
               1: begin   // corrupt tail magic
                  at = 10 + hlen + blen + $urandom_range(0, 1);
                  frame_q[at] = frame_q[at] ^ (8'h01 << $urandom_range(0, 7));
               end
               2: begin   // buffer cut short
                  cut = $urandom_range(1, frame_q.size() - 1);
                  while (frame_q.size() > cut) void'(frame_q.pop_back());
               end
               default: ;
            endcase
         end else if (kind < 72) begin
            // lengths anywhere in range, buffer far too short for them
            put16(cfg_head_magic);
            put16(16'($urandom));
            put16(16'($urandom));
            put32($urandom);
            put_random($urandom_range(2, 20));
         end else if (kind < 86) begin
            // under the minimum, sometimes starting like a real frame
            if ($urandom_range(0, 1) == 0) begin
               put16(cfg_head_magic);
               put_random($urandom_range(0, 9));
            end else begin
               put_random($urandom_range(1, 11));
            end
         end else begin
            put_random($urandom_range(12, 30));
         end
         send_frame();
      end
   endtask

   // Wait until every expected word is back and the pipe is empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (deframed_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input mld_pkg::csr_index_type idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == mld_pkg::CSR_HEAD_MAGIC)
         cfg_head_magic = value;
      else
         cfg_tail_magic = value;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Receiver side: random stall bursts, plus one long hold when asked
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < 40)
         $display("mismatch word %0d %s: got %h want %h", words_checked, what, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------------------
   // Result checker, field by field against the oldest expected word
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      mld_pkg::rsp_word_type w;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (deframed_q.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[31:0], 32'd0);
         end else begin
            w = deframed_q.pop_front();
            if (rsp_tdata[7:0] !== w.out_byte)
               report_mismatch("out_byte", rsp_tdata[7:0], w.out_byte);
            if (rsp_tuser !== w.region)
               report_mismatch("region", rsp_tuser, w.region);
            if (rsp_tdata[23:8] !== w.command_id)
               report_mismatch("command_id", rsp_tdata[23:8], w.command_id);
            if (rsp_tdata[39:24] !== w.head_length)
               report_mismatch("head_length", rsp_tdata[39:24], w.head_length);
            if (rsp_tdata[71:40] !== w.body_length)
               report_mismatch("body_length", rsp_tdata[71:40], w.body_length);
            if (rsp_tlast !== w.done_res)
               report_mismatch("done_res", rsp_tlast, w.done_res);
            if (rsp_tdata[74:72] !== w.status)
               report_mismatch("status", rsp_tdata[74:72], w.status);
         end
         words_checked++;
      end
   end

   // watchdog: cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready === 1'b1) ||
          (rsp_tvalid === 1'b1 && rsp_tready)) begin
         idle_count <= 0;
      end else if (idle_count >= WATCHDOG_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Directed buffers: a lone byte, a minimal frame with a stray byte past its
   // tail, and a frame whose all-ones lengths can never fit in the buffer
   // ---------------------------------------------------------------------------
   directed_row_type directed_rows [0:25] = '{
      '{8'h00, 1'b1, 1'b1, mld_pkg::STATUS_UNDER_MIN},
      '{8'h45, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'h67, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'h00, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'h00, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'h00, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'h00, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'h00, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'h00, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'h00, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'h00, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'h89, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'hAB, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'h3C, 1'b1, 1'b1, mld_pkg::STATUS_OK},
      '{8'h45, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'h67, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'hFF, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'h00, 1'b0, 1'b0, mld_pkg::STATUS_OK},
      '{8'h00, 1'b1, 1'b1, mld_pkg::STATUS_SHORT}
   };

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      cfg_head_magic = mld_pkg::HEAD_MAGIC_RESET;
      cfg_tail_magic = mld_pkg::TAIL_MAGIC_RESET;
      clear_capture();
      idling_on = 1'b1;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].status);

      random_traffic(200);
      settle();

      // all-zero head magic, all-ones tail; rsp_ held off while req_ keeps offering
      write_csr(mld_pkg::CSR_HEAD_MAGIC, 16'h0000);
      write_csr(mld_pkg::CSR_TAIL_MAGIC, 16'hFFFF);
      hold_pending = 1'b1;
      random_traffic(225);
      settle();

      write_csr(mld_pkg::CSR_HEAD_MAGIC, 16'hFFFF);
      write_csr(mld_pkg::CSR_TAIL_MAGIC, 16'h0000);
      random_traffic(225);
      settle();

      // random magics, full rate on both sides to the end
      write_csr(mld_pkg::CSR_HEAD_MAGIC, 16'($urandom));
      write_csr(mld_pkg::CSR_TAIL_MAGIC, 16'($urandom));
      idling_on = 1'b0;
      random_traffic(250);
      settle();

      if (error_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sim.f =====
design/mld_pkg.sv
design/mld_in_reg.sv
design/mld_parser.sv
design/mld_out_reg.sv
design/magic_length_deframer_core.sv
test/testbench.sv
